// ===== hdl/circle_box_collision_test_assert.svh =====
// Assertion macros for the circle/box collision tester.
// Plain text, no dependencies; included by modules that check their own logic.
`ifndef CIRCLE_BOX_COLLISION_TEST_ASSERT_SVH
`define CIRCLE_BOX_COLLISION_TEST_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define CBCT_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CBCT_ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cbct_pkg.sv =====
// Shared types and constants of the circle/box collision tester.
// No dependencies; imported by cbct_dist_cmp and circle_box_collision_test.
`default_nettype none

package cbct_pkg;

  // func codes on the input tuser
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEST = 1'b1;

  localparam int unsigned SCALE_FRAC = 8;   // Q8.8 scale
  localparam int unsigned CTR_W      = 27;  // centre, half units
  localparam int unsigned BOX_W      = 32;  // scaled size
  localparam int unsigned GAP_W      = 27;  // per-axis distance magnitude
  localparam int unsigned DEPTH_W    = 27;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
  localparam logic [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

  // control carried into the distance compare stages
  typedef struct packed {
    logic valid;
    logic dead;      // one side not alive, never hits
    logic box_pair;  // both boxes, use the overlap result
    logic box_hit;   // strict overlap on both axes
    logic rad_big;   // radius sum beyond any reachable distance
  } cmp_req_t;

endpackage

`default_nettype wire

// ===== hdl/circle_box_collision_test.sv =====
// Circle/box collision tester top level: collider build, reference store, gap and depth.
// Depends on cbct_pkg, cbct_dist_cmp and circle_box_collision_test_assert.svh.
//
//  channel  dir  tdata (low bit up)                                   tuser
//  s_axis   in   pos_x 24, pos_y 24, sprite_width 24, sprite_height   func 1
//                24, offset_x 24, offset_y 24, scale_x 16, scale_y 16,
//                collider_type 1, alive 1, zero pad to 184
//  m_axis   out  hit 1, depth_x 27, depth_y 27, zero pad to 56         -
//
// One word per cycle on both sides while the pipeline is not held; a test word passes
// through the five register stages (build, reference, gap, square, compare).
// A load word updates the reference in the second stage and gives no output word.
// Reset clears the pipeline valid bits and sets the reference to a live zero box.
// While the output word waits, the whole pipeline holds and s_axis_tready_o is low.
`default_nettype none
`include "circle_box_collision_test_assert.svh"

module circle_box_collision_test
  import cbct_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // pos_x, pos_y, sprite_width, sprite_height, offset_x, offset_y,
  // scale_x, scale_y, collider_type, alive
  input  wire logic [183:0] s_axis_tdata_i,
  input  wire logic         s_axis_tuser_i,   // func
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [55:0]       m_axis_tdata_o    // hit, depth_x, depth_y
);

  localparam int unsigned PROD_W = 40;
  localparam int unsigned DIFF_W = CTR_W + 1;
  localparam int unsigned SUM_W  = BOX_W + 1;

  logic en;

  // ---------------- build stage ----------------
  logic [23:0] pos_x, pos_y, spr_w, spr_h, off_x, off_y;
  logic [15:0] scl_x, scl_y;
  logic [CTR_W-1:0]  cx_a, cy_a;
  logic [PROD_W-1:0] prod_x, prod_y;

  assign pos_x = s_axis_tdata_i[23:0];
  assign pos_y = s_axis_tdata_i[47:24];
  assign spr_w = s_axis_tdata_i[71:48];
  assign spr_h = s_axis_tdata_i[95:72];
  assign off_x = s_axis_tdata_i[119:96];
  assign off_y = s_axis_tdata_i[143:120];
  assign scl_x = s_axis_tdata_i[159:144];
  assign scl_y = s_axis_tdata_i[175:160];

  // centre in half units: 2*pos + size + 2*offset
  assign cx_a = {{2{pos_x[23]}}, pos_x, 1'b0} + {3'b000, spr_w}
              + {{2{off_x[23]}}, off_x, 1'b0};
  assign cy_a = {{2{pos_y[23]}}, pos_y, 1'b0} + {3'b000, spr_h}
              + {{2{off_y[23]}}, off_y, 1'b0};
  assign prod_x = {16'd0, spr_w} * {24'd0, scl_x};
  assign prod_y = {16'd0, spr_h} * {24'd0, scl_y};

  logic             v1_q, func1_q, circ1_q, alive1_q;
  logic [CTR_W-1:0] cx1_q, cy1_q;
  logic [BOX_W-1:0] wx1_q, wy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      func1_q  <= s_axis_tuser_i;
      circ1_q  <= s_axis_tdata_i[176];
      alive1_q <= s_axis_tdata_i[177];
      cx1_q    <= cx_a;
      cy1_q    <= cy_a;
      wx1_q    <= prod_x[PROD_W-1:SCALE_FRAC];
      wy1_q    <= prod_y[PROD_W-1:SCALE_FRAC];
    end
  end

  // ---------------- reference stage ----------------
  logic             ref_circ_q, ref_alive_q;
  logic [CTR_W-1:0] ref_cx_q, ref_cy_q;
  logic [BOX_W-1:0] ref_wx_q, ref_wy_q, ref_r_q;
  logic [BOX_W-1:0] r_b;
  logic             ld_b, test_b;
  logic [DIFF_W-1:0] diff_x_b, diff_y_b;
  logic [SUM_W-1:0]  rad_b;

  assign r_b    = (wx1_q > wy1_q) ? wx1_q : wy1_q;
  assign ld_b   = en && v1_q && (func1_q == FUNC_LOAD);
  assign test_b = v1_q && (func1_q == FUNC_TEST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_cx_q    <= '0;
      ref_cy_q    <= '0;
      ref_wx_q    <= '0;
      ref_wy_q    <= '0;
      ref_r_q     <= '0;
      ref_circ_q  <= 1'b0;
      ref_alive_q <= 1'b1;
    end else if (ld_b) begin
      ref_cx_q    <= cx1_q;
      ref_cy_q    <= cy1_q;
      ref_wx_q    <= wx1_q;
      ref_wy_q    <= wy1_q;
      ref_r_q     <= r_b;
      ref_circ_q  <= circ1_q;
      ref_alive_q <= alive1_q;
    end
  end

  // reference minus tested centre
  assign diff_x_b = {ref_cx_q[CTR_W-1], ref_cx_q} - {cx1_q[CTR_W-1], cx1_q};
  assign diff_y_b = {ref_cy_q[CTR_W-1], ref_cy_q} - {cy1_q[CTR_W-1], cy1_q};

  always_comb begin
    if (circ1_q && ref_circ_q) begin
      rad_b = {1'b0, r_b} + {1'b0, ref_r_q};
    end else if (circ1_q) begin
      rad_b = {1'b0, r_b};
    end else begin
      rad_b = {1'b0, ref_r_q};
    end
  end

  logic              v2_q, dead2_q, cc2_q, bb2_q, nzx2_q, nzy2_q;
  logic [DIFF_W-1:0] dfx2_q, dfy2_q;
  logic [SUM_W-1:0]  sumx2_q, sumy2_q, rad2_q;
  logic [BOX_W-1:0]  wbx2_q, wby2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= test_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dead2_q <= !alive1_q || !ref_alive_q;
      cc2_q   <= circ1_q && ref_circ_q;
      bb2_q   <= !circ1_q && !ref_circ_q;
      nzx2_q  <= (wx1_q != '0) && (ref_wx_q != '0);
      nzy2_q  <= (wy1_q != '0) && (ref_wy_q != '0);
      dfx2_q  <= diff_x_b;
      dfy2_q  <= diff_y_b;
      sumx2_q <= {1'b0, wx1_q} + {1'b0, ref_wx_q};
      sumy2_q <= {1'b0, wy1_q} + {1'b0, ref_wy_q};
      // box side of a circle against box pair
      wbx2_q  <= circ1_q ? ref_wx_q : wx1_q;
      wby2_q  <= circ1_q ? ref_wy_q : wy1_q;
      rad2_q  <= rad_b;
    end
  end

  // ---------------- gap and depth stage ----------------
  function automatic logic [GAP_W-1:0] mag(input logic [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] n;
    n = '0 - d;
    return d[DIFF_W-1] ? n[GAP_W-1:0] : d[GAP_W-1:0];
  endfunction

  // distance from the circle centre to the box along one axis
  function automatic logic [GAP_W-1:0] gap(input logic [GAP_W-1:0] a,
                                           input logic [BOX_W-1:0] w);
    logic [BOX_W:0] t;
    t = {{(BOX_W+1-GAP_W){1'b0}}, a} - {1'b0, w};
    return t[BOX_W] ? '0 : t[GAP_W-1:0];
  endfunction

  // (diff - sign(diff) * sum) / 2, floored, saturated
  function automatic logic [DEPTH_W-1:0] depth_sat(input logic [DIFF_W-1:0] d,
                                                   input logic [SUM_W-1:0]  s);
    logic [SUM_W+1:0] dd;
    logic [SUM_W+1:0] q;
    dd = d[DIFF_W-1] ? ({{(SUM_W+2-DIFF_W){d[DIFF_W-1]}}, d} + {2'b00, s})
                     : ({{(SUM_W+2-DIFF_W){d[DIFF_W-1]}}, d} - {2'b00, s});
    q = {dd[SUM_W+1], dd[SUM_W+1:1]};
    if (!q[SUM_W+1] && (q[SUM_W:DEPTH_W-1] != '0)) begin
      return DEPTH_MAX;
    end else if (q[SUM_W+1] && (q[SUM_W:DEPTH_W-1] != '1)) begin
      return DEPTH_MIN;
    end else begin
      return q[DEPTH_W-1:0];
    end
  endfunction

  logic [GAP_W-1:0] ax_c, ay_c, ex_c, ey_c;
  logic             bbx_c, bby_c;

  assign ax_c  = mag(dfx2_q);
  assign ay_c  = mag(dfy2_q);
  assign ex_c  = cc2_q ? ax_c : gap(ax_c, wbx2_q);
  assign ey_c  = cc2_q ? ay_c : gap(ay_c, wby2_q);
  assign bbx_c = nzx2_q && ({{(SUM_W-GAP_W){1'b0}}, ax_c} < sumx2_q);
  assign bby_c = nzy2_q && ({{(SUM_W-GAP_W){1'b0}}, ay_c} < sumy2_q);

  cmp_req_t           req3_q;
  logic [GAP_W-1:0]   ex3_q, ey3_q;
  logic [BOX_W-1:0]   rad3_q;
  logic [DEPTH_W-1:0] dx3_q, dy3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req3_q <= '0;
    end else if (en) begin
      req3_q.valid    <= v2_q;
      req3_q.dead     <= dead2_q;
      req3_q.box_pair <= bb2_q;
      req3_q.box_hit  <= bbx_c && bby_c;
      req3_q.rad_big  <= cc2_q && (rad2_q[SUM_W-1:SUM_W-2] != 2'b00);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex3_q           <= ex_c;
      ey3_q           <= ey_c;
      rad3_q          <= rad2_q[BOX_W-1:0];
      dx3_q           <= depth_sat(dfx2_q, sumx2_q);
      dy3_q           <= depth_sat(dfy2_q, sumy2_q);
    end
  end

  // ---------------- square and compare stages ----------------
  logic               out_v, out_hit;
  logic [DEPTH_W-1:0] out_dx, out_dy;

  cbct_dist_cmp u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .req_i     (req3_q),
    .ex_i      (ex3_q),
    .ey_i      (ey3_q),
    .rad_i     (rad3_q),
    .depth_x_i (dx3_q),
    .depth_y_i (dy3_q),
    .valid_o   (out_v),
    .hit_o     (out_hit),
    .depth_x_o (out_dx),
    .depth_y_o (out_dy)
  );

  // hold everything while the output word waits
  assign en              = !out_v || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_v;
  assign m_axis_tdata_o  = {1'b0, out_dy, out_dx, out_hit};

  `CBCT_ASSERT_RST(a_ref_from_load, clk_i, rst_ni, !$stable(ref_cx_q) |-> $past(ld_b), "reference centre changed without a load word")
  `CBCT_ASSERT_RST(a_load_no_result, clk_i, rst_ni, ld_b |=> !v2_q, "load word passed the reference stage")
  `CBCT_ASSERT_RST(a_valid_advance, clk_i, rst_ni, en |=> (req3_q.valid == $past(v2_q)), "valid bit lost or repeated in gap stage")
  `CBCT_ASSERT_CLK(a_reset_idle, clk_i, !rst_ni |-> !m_axis_tvalid_o, "output word valid during reset")

endmodule

`default_nettype wire

// ===== hdl/cbct_dist_cmp.sv =====
// Squared distance against squared radius: the last two pipeline stages, the second one
// registering the output word. Depends on cbct_pkg.
`default_nettype none

module cbct_dist_cmp
  import cbct_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire cmp_req_t             req_i,
  input  wire logic [GAP_W-1:0]     ex_i,
  input  wire logic [GAP_W-1:0]     ey_i,
  input  wire logic [BOX_W-1:0]     rad_i,
  input  wire logic [DEPTH_W-1:0]   depth_x_i,
  input  wire logic [DEPTH_W-1:0]   depth_y_i,
  output logic                      valid_o,
  output logic                      hit_o,
  output logic [DEPTH_W-1:0]        depth_x_o,
  output logic [DEPTH_W-1:0]        depth_y_o
);

  localparam int unsigned SQ_W  = 2 * GAP_W;
  localparam int unsigned RSQ_W = 2 * BOX_W;

  cmp_req_t           req_q;
  logic [SQ_W-1:0]    sqx_q, sqy_q;
  logic [RSQ_W-1:0]   rsq_q;
  logic [DEPTH_W-1:0] dx_q, dy_q;

  logic [SQ_W:0]      d2;
  logic               hit_d;
  logic               valid_q, hit_q;
  logic [DEPTH_W-1:0] dxo_q, dyo_q;

  // square stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
    end else if (en_i) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q <= ex_i * ex_i;
      sqy_q <= ey_i * ey_i;
      rsq_q <= rad_i * rad_i;
      dx_q  <= depth_x_i;
      dy_q  <= depth_y_i;
    end
  end

  // compare stage
  assign d2 = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_comb begin
    if (req_q.dead) begin
      hit_d = 1'b0;
    end else if (req_q.box_pair) begin
      hit_d = req_q.box_hit;
    end else if (req_q.rad_big) begin
      hit_d = 1'b1;
    end else begin
      hit_d = ({{(RSQ_W-SQ_W-1){1'b0}}, d2} <= rsq_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= req_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= hit_d;
      dxo_q <= dx_q;
      dyo_q <= dy_q;
    end
  end

  assign valid_o   = valid_q;
  assign hit_o     = hit_q;
  assign depth_x_o = dxo_q;
  assign depth_y_o = dyo_q;

endmodule

`default_nettype wire
